// File: hw/rtl/olist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine: list depth,
// derived widths, operation and status codes, sequencer states and the
// structs that travel between the sequencer, the entry RAM and the top level.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W     = 4;
    localparam int POS_W    = 4;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int SIZE_W   = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SIZE_X_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT    = 4'd0,
        OP_REMOVE_AT    = 4'd1,
        OP_DELETE_MATCH = 4'd2,
        OP_SEARCH       = 4'd3,
        OP_READ_AT      = 4'd4,
        OP_SIZE         = 4'd5,
        OP_ADD_HEAD     = 4'd6,
        OP_ADD_TAIL     = 4'd7,
        OP_REMOVE_HEAD  = 4'd8,
        OP_REMOVE_TAIL  = 4'd9
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  value;
        logic [SIZE_W-1:0] size;
    } result_t;

endpackage

// File: hw/rtl/olist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_mem
// Entry storage: one write port and one read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module olist_mem
    import olist_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/olist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ctrl
// Sequencer for the list: decodes one operation, then walks the entry RAM
// one address per cycle through a shared address stepper and compare unit,
// scanning for a match or shifting entries up or down by one place.
// ----------------------------------------------------------------------------
module olist_ctrl
    import olist_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_take,
    input  logic [OP_W-1:0]  in_op,
    input  logic [POS_W-1:0] in_pos,
    input  logic [VAL_W-1:0] in_value,
    input  logic             out_free,
    input  logic [VAL_W-1:0] rdata,
    output logic             in_ready,
    output logic             done,
    output result_t          result,
    output mem_req_t         mem_req
);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0] rd_last_reg, rd_last_next;
    logic [IDX_W-1:0] wb_addr_reg, wb_addr_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic             rd_on_reg, rd_on_next;
    logic             wb_on_reg, wb_on_next;
    logic             first_reg, first_next;
    logic             up_reg, up_next;
    status_t          status_reg, status_next;
    logic [VAL_W-1:0] res_reg, res_next;

    logic                count_full;
    logic                count_zero;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                pos_in;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    cnt_idx;
    logic [IDX_W-1:0]    ins_idx;
    logic                hit;
    logic                walk_idle;
    logic                rd_at_last;
    logic [SIZE_X_W-1:0] size_ext;

    assign count_full = (count_reg == CNT_W'(DEPTH));
    assign count_zero = (count_reg == '0);
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign pos_ext    = CMP_W'(pos_reg);
    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_in     = (pos_ext < cnt_ext);
    assign pos_idx    = pos_ext[IDX_W-1:0];
    assign cnt_idx    = count_reg[IDX_W-1:0];
    assign hit        = wb_on_reg && (rdata == val_reg);
    assign walk_idle  = !rd_on_reg && !wb_on_reg;
    assign rd_at_last = (rd_addr_reg == rd_last_reg);
    assign size_ext   = SIZE_X_W'(count_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_ADD_HEAD: ins_idx = '0;
            OP_ADD_TAIL: ins_idx = cnt_idx;
            default:     ins_idx = pos_in ? pos_idx : cnt_idx;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_INSERT_AT, OP_ADD_HEAD, OP_ADD_TAIL:
                        state_next = count_full ? S_DONE : S_SHIFT;
                    OP_REMOVE_AT, OP_READ_AT:
                        state_next = pos_in ? S_SHIFT : S_DONE;
                    OP_DELETE_MATCH, OP_SEARCH:
                        state_next = count_zero ? S_DONE : S_SCAN;
                    OP_REMOVE_HEAD, OP_REMOVE_TAIL:
                        state_next = count_zero ? S_DONE : S_SHIFT;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_SEARCH) ? S_DONE : S_SHIFT;
                end
                else if (walk_idle)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (walk_idle)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        rd_addr_next = rd_addr_reg;
        rd_last_next = rd_last_reg;
        wb_addr_next = wb_addr_reg;
        t_next       = t_reg;
        rd_on_next   = rd_on_reg;
        wb_on_next   = wb_on_reg;
        first_next   = first_reg;
        up_next      = up_reg;
        status_next  = status_reg;
        res_next     = res_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = up_reg ? (wb_addr_reg + IDX_W'(1)) : (wb_addr_reg - IDX_W'(1));
        mem_req.wdata = rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = rd_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next  = op_t'(in_op);
                    pos_next = in_pos;
                    val_next = in_value;
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                res_next    = '0;
                first_next  = 1'b0;
                wb_on_next  = 1'b0;
                rd_on_next  = 1'b0;
                up_next     = 1'b0;
                rd_last_next = cnt_m1[IDX_W-1:0];
                unique case (op_reg)
                    OP_INSERT_AT, OP_ADD_HEAD, OP_ADD_TAIL:
                    begin
                        if (count_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // shift the tail end up, last entry first
                            up_next      = 1'b1;
                            t_next       = ins_idx;
                            rd_addr_next = cnt_m1[IDX_W-1:0];
                            rd_last_next = ins_idx;
                            rd_on_next   = (count_reg != CNT_W'(ins_idx));
                        end
                    end
                    OP_REMOVE_AT, OP_READ_AT:
                    begin
                        if (pos_in)
                        begin
                            first_next   = 1'b1;
                            rd_addr_next = pos_idx;
                            rd_on_next   = 1'b1;
                            if (op_reg == OP_READ_AT)
                            begin
                                rd_last_next = pos_idx;
                            end
                        end
                        else
                        begin
                            status_next = ST_MISS;
                        end
                    end
                    OP_DELETE_MATCH, OP_SEARCH, OP_REMOVE_HEAD, OP_REMOVE_TAIL:
                    begin
                        if (count_zero)
                        begin
                            status_next = ST_MISS;
                        end
                        else
                        begin
                            first_next   = (op_reg == OP_REMOVE_HEAD) ||
                                           (op_reg == OP_REMOVE_TAIL);
                            rd_addr_next = (op_reg == OP_REMOVE_TAIL) ?
                                           cnt_m1[IDX_W-1:0] : '0;
                            rd_on_next   = 1'b1;
                        end
                    end
                    OP_SIZE:
                    begin
                        status_next = ST_OK;
                    end
                    default:
                    begin
                        status_next = ST_MISS;
                    end
                endcase
            end
            S_SCAN:
            begin
                mem_req.re   = rd_on_reg;
                wb_on_next   = rd_on_reg;
                wb_addr_next = rd_addr_reg;
                if (rd_on_reg)
                begin
                    if (rd_at_last)
                    begin
                        rd_on_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + IDX_W'(1);
                    end
                end
                if (hit)
                begin
                    if (op_reg == OP_DELETE_MATCH)
                    begin
                        // restart the walk at the match and close the gap
                        up_next      = 1'b0;
                        first_next   = 1'b1;
                        rd_addr_next = wb_addr_reg;
                        rd_last_next = cnt_m1[IDX_W-1:0];
                        rd_on_next   = 1'b1;
                        wb_on_next   = 1'b0;
                    end
                    else
                    begin
                        rd_on_next = 1'b0;
                        wb_on_next = 1'b0;
                    end
                end
                else if (walk_idle)
                begin
                    status_next = ST_MISS;
                end
            end
            S_SHIFT:
            begin
                mem_req.re   = rd_on_reg;
                wb_on_next   = rd_on_reg;
                wb_addr_next = rd_addr_reg;
                if (rd_on_reg)
                begin
                    if (rd_at_last)
                    begin
                        rd_on_next = 1'b0;
                    end
                    else if (up_reg)
                    begin
                        rd_addr_next = rd_addr_reg - IDX_W'(1);
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + IDX_W'(1);
                    end
                end
                if (wb_on_reg)
                begin
                    if (!up_reg && first_reg)
                    begin
                        // first word read on a removal or an indexed read is the taken value
                        res_next   = rdata;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                    end
                end
                if (walk_idle)
                begin
                    if (up_reg)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = t_reg;
                        mem_req.wdata = val_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    else if (op_reg != OP_READ_AT)
                    begin
                        count_next = cnt_m1;
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_on_reg <= 1'b0;
            wb_on_reg <= 1'b0;
            first_reg <= 1'b0;
            up_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_on_reg <= rd_on_next;
            wb_on_reg <= wb_on_next;
            first_reg <= first_next;
            up_reg    <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        rd_addr_reg <= rd_addr_next;
        rd_last_reg <= rd_last_next;
        wb_addr_reg <= wb_addr_next;
        t_reg       <= t_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign done          = (state_reg == S_DONE) && out_free;
    assign result.status = status_reg;
    assign result.value  = res_reg;
    assign result.size   = size_ext[SIZE_W-1:0];

endmodule

// File: hw/rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values with indexed insert, remove, read,
// match search and delete, and head/tail access, kept in a RAM with one read
// and one write port.
// ----------------------------------------------------------------------------
// Sequence: size, unknown op, full and out-of-range cases go from decode
//   straight to done; an append at the tail passes the shift state with no
//   RAM reads; an indexed walk or a search reads entries in turn; a match
//   delete scans then shifts. Walks make one RAM read per cycle.
// Throughput: one operation at a time; the next input is taken as the result
//   turns valid, while it still sits in the output register.
// Reset: asynchronous, empties the list; RAM contents are not cleared.
module ordered_list_engine
    import olist_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op[3:0], position[7:4], item_value[39:8]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], result_value[33:2],
                                        // list_size[38:34], zero[39]
);

    logic             in_take;
    logic             out_free;
    logic             done;
    result_t          result;
    mem_req_t         mem_req;
    logic [VAL_W-1:0] rdata;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    olist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .in_op    (s_tdata[3:0]),
        .in_pos   (s_tdata[7:4]),
        .in_value (s_tdata[39:8]),
        .out_free (out_free),
        .rdata    (rdata),
        .in_ready (s_tready),
        .done     (done),
        .result   (result),
        .mem_req  (mem_req)
    );

    olist_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, result.size, result.value, result.status};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/olist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_checker
// Port-level checks for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module olist_checker
    import olist_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one operation in flight: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // value is zero unless the status is ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == '0))
        else $error("nonzero value on failed operation");

    // a refused insert only happens with the list at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_FULL) |-> (m_tdata[38:34] == SIZE_W'(DEPTH)))
        else $error("full status with room left");

endmodule

bind ordered_list_engine olist_checker u_olist_checker (.*);

// File: tb/tb_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Self-checking bench for the ordered list engine. A table of directed
// operations covers the empty list, extreme values, inserts past the end, a
// full list and the unused op codes. Random phases follow: they grow, shrink
// and churn the list, and search for live values. Each accepted operation
// runs through a local list model, and every result transfer is checked field
// by field against it or the typed row. Both stream sides idle at random, and
// the output side holds off twice, long enough that the engine backs up.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
    import olist_pkg::*;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd10;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int MAX_GAP       = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 2 * DEPTH + 6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic [3:0]        reps;
        logic              typed;
        status_t           st;
        logic [VAL_W-1:0]  rv;
        logic [SIZE_W-1:0] sz;
    } dir_row_t;

    localparam int N_ROWS = 26;
    localparam dir_row_t DIR_ROWS [N_ROWS] = '{
        '{OP_SIZE,         4'd0,  32'h0000_0000, 4'd1,  1'b1, ST_OK,   32'd0, 5'd0},
        '{OP_REMOVE_HEAD,  4'd0,  32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_REMOVE_TAIL,  4'd0,  32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_READ_AT,      4'd0,  32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_REMOVE_AT,    4'd15, 32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_SEARCH,       4'd0,  32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_DELETE_MATCH, 4'd0,  32'hFFFF_FFFF, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_FIRST_UNUSED, 4'd0,  32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_LAST_UNUSED,  4'd15, 32'hFFFF_FFFF, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd0},
        '{OP_INSERT_AT,    4'd15, 32'h8000_0000, 4'd1,  1'b1, ST_OK,   32'd0, 5'd1},
        '{OP_ADD_HEAD,     4'd0,  32'h7FFF_FFFF, 4'd1,  1'b1, ST_OK,   32'd0, 5'd2},
        '{OP_ADD_TAIL,     4'd0,  32'hFFFF_FFFF, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_INSERT_AT,    4'd1,  32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_SEARCH,       4'd0,  32'h8000_0000, 4'd1,  1'b1, ST_OK,   32'd0, 5'd4},
        '{OP_READ_AT,      4'd3,  32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_READ_AT,      4'd4,  32'h0000_0000, 4'd1,  1'b1, ST_MISS, 32'd0, 5'd4},
        '{OP_ADD_TAIL,     4'd0,  32'h5A5A_A5A5, 4'd12, 1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_INSERT_AT,    4'd0,  32'h0000_0001, 4'd1,  1'b1, ST_FULL, 32'd0, 5'd16},
        '{OP_ADD_HEAD,     4'd0,  32'h0000_0001, 4'd1,  1'b1, ST_FULL, 32'd0, 5'd16},
        '{OP_ADD_TAIL,     4'd0,  32'h0000_0001, 4'd1,  1'b1, ST_FULL, 32'd0, 5'd16},
        '{OP_DELETE_MATCH, 4'd0,  32'h5A5A_A5A5, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_REMOVE_AT,    4'd15, 32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_REMOVE_AT,    4'd14, 32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_REMOVE_HEAD,  4'd0,  32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_REMOVE_TAIL,  4'd0,  32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0},
        '{OP_REMOVE_AT,    4'd0,  32'h0000_0000, 4'd1,  1'b0, ST_OK,   32'd0, 5'd0}
    };

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    // local copy of the list, updated in transfer order
    logic [VAL_W-1:0] list_vals [DEPTH];
    int               list_len;
    result_t          pending_results [$];
    int               mismatch_count;
    bit               burst_mode;
    bit               hold_req;

    ordered_list_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [VAL_W-1:0] list_take(int idx);
        logic [VAL_W-1:0] v;
        v = list_vals[idx];
        for (int i = idx; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i + 1];
        list_len--;
        return v;
    endfunction

    function automatic result_t list_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                           logic [VAL_W-1:0] val);
        result_t r;
        int      at;
        r.status = ST_OK;
        r.value  = '0;
        case (op)
            OP_INSERT_AT, OP_ADD_HEAD, OP_ADD_TAIL:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // an index past the end appends at the tail
                    at = (op == OP_ADD_HEAD) ? 0 :
                         (op == OP_ADD_TAIL || int'(pos) > list_len) ? list_len : int'(pos);
                    for (int i = list_len; i > at; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[at] = val;
                    list_len++;
                end
            end
            OP_REMOVE_AT:
                if (int'(pos) < list_len) r.value = list_take(int'(pos));
                else r.status = ST_MISS;
            OP_READ_AT:
                if (int'(pos) < list_len) r.value = list_vals[pos];
                else r.status = ST_MISS;
            OP_DELETE_MATCH, OP_SEARCH:
            begin
                at = -1;
                for (int i = 0; i < list_len && at < 0; i++)
                    if (list_vals[i] == val) at = i;
                if (at < 0) r.status = ST_MISS;
                else if (op == OP_DELETE_MATCH) r.value = list_take(at);
            end
            OP_SIZE: ;
            OP_REMOVE_HEAD:
                if (list_len > 0) r.value = list_take(0);
                else r.status = ST_MISS;
            OP_REMOVE_TAIL:
                if (list_len > 0) r.value = list_take(list_len - 1);
                else r.status = ST_MISS;
            default:
                r.status = ST_MISS;
        endcase
        r.size = SIZE_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Drive one operation; valid stays high across back-to-back transfers.
    task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           bit typed, result_t fixed);
        int      gap;
        result_t r;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        r = list_apply(op, pos, val);
        pending_results.push_back(typed ? fixed : r);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30 && list_len > 0)
            return list_vals[$urandom_range(0, list_len - 1)];
        else if (k < 45)
            return VAL_W'($urandom_range(0, 3)) - 32'd1;
        else if (k < 55)
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        return $urandom;
    endfunction

    // Result side: random stalls, one long hold on request.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result transfer", '0, m_tdata[VAL_W-1:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[STAT_W-1:0] != want.status)
                    report_mismatch("status", VAL_W'(want.status),
                                    VAL_W'(m_tdata[STAT_W-1:0]));
                if (m_tdata[STAT_W +: VAL_W] != want.value)
                    report_mismatch("result_value", want.value, m_tdata[STAT_W +: VAL_W]);
                if (m_tdata[STAT_W + VAL_W +: SIZE_W] != want.size)
                    report_mismatch("list_size", VAL_W'(want.size),
                                    VAL_W'(m_tdata[STAT_W + VAL_W +: SIZE_W]));
            end
        end
    end

    initial
    begin
        result_t          fixed;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int               n_sent;
        int               phase;
        int               phase_len;
        int               kind;
        int               guard;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        list_len       = 0;
        mismatch_count = 0;
        burst_mode     = 1'b0;
        hold_req       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < N_ROWS; row++)
        begin
            fixed.status = DIR_ROWS[row].st;
            fixed.value  = DIR_ROWS[row].rv;
            fixed.size   = DIR_ROWS[row].sz;
            repeat (DIR_ROWS[row].reps)
                send_op(DIR_ROWS[row].op, DIR_ROWS[row].pos, DIR_ROWS[row].val,
                        DIR_ROWS[row].typed, fixed);
        end

        // kinds: 0 grow, 1 shrink, 2 churn over valid ops, 3 noise with unused ops
        n_sent = 0;
        phase  = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            kind       = $urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : 3;
            phase_len  = $urandom_range(10, 60);
            burst_mode = ($urandom_range(0, 3) == 0);
            if (phase == 2 || phase == 20)
            begin
                burst_mode = 1'b1;
                hold_req   = 1'b1;
            end
            repeat (phase_len)
            begin
                if (kind == 0 && $urandom_range(0, 9) < 6)
                    case ($urandom_range(0, 2))
                        0: op = OP_INSERT_AT;
                        1: op = OP_ADD_HEAD;
                        default: op = OP_ADD_TAIL;
                    endcase
                else if (kind == 1 && $urandom_range(0, 9) < 6)
                    case ($urandom_range(0, 3))
                        0: op = OP_REMOVE_AT;
                        1: op = OP_DELETE_MATCH;
                        2: op = OP_REMOVE_HEAD;
                        default: op = OP_REMOVE_TAIL;
                    endcase
                else if (kind == 3)
                    op = OP_W'($urandom_range(0, OP_LAST_UNUSED));
                else
                    op = OP_W'($urandom_range(0, OP_REMOVE_TAIL));
                if (list_len > 0 && $urandom_range(0, 9) < 7)
                    pos = POS_W'($urandom_range(0, list_len > 15 ? 15 : list_len));
                else
                    pos = POS_W'($urandom_range(0, 15));
                send_op(op, pos, pick_value(), 1'b0, fixed);
                n_sent++;
            end
            phase++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_mode = 1'b0;
        guard = 0;
        while (pending_results.size() > 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
